[hw/rtl/lsms_pkg.sv]
// ----------------------------------------------------------------------------
// lsms_pkg
// Shared types, codes and helper functions of the LED strip mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsms_pkg;

  localparam int unsigned MS_W    = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned RGBW_W  = 4 * COLOR_W;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = MS_W;

  localparam logic [COLOR_W-1:0] LEVEL_DIM  = 8'd40;
  localparam logic [COLOR_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] LEVEL_ZERO = 8'd0;

  localparam logic [MS_W-1:0] IDLE_FADE_MS   = 31'd5000;
  localparam logic [MS_W-1:0] ACTIVE_FADE_MS = 31'd500;
  localparam logic [MS_W-1:0] OFF_FADE_MS    = 31'd500;
  localparam logic [MS_W-1:0] TIMEOUT_RST_MS = 31'd60000;

  typedef enum logic [MODE_W-1:0] {
    MODE_STARTUP = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_ACTIVE  = 3'd2,
    MODE_CUSTOM  = 3'd3,
    MODE_ENDLESS = 3'd4,
    MODE_SETOFF  = 3'd5,
    MODE_OFF     = 3'd6
  } mode_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_PING      = 3'd1,
    FUNC_PRESENT   = 3'd2,
    FUNC_ENABLE    = 3'd3,
    FUNC_DISABLE   = 3'd4,
    FUNC_PANIC_OFF = 3'd5
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMMING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDLESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic            dimming;
    logic            white;
    logic            endless;
    logic [MS_W-1:0] timeout;
  } cfg_t;

  // Colors are packed with red in the low byte and white in the high byte.
  typedef struct packed {
    mode_t             mode;
    logic              ping_valid;
    logic [TIME_W-1:0] ping_time;
    logic              custom_valid;
    logic [RGBW_W-1:0] custom_rgbw;
    logic [MS_W-1:0]   custom_fade;
    logic [MS_W-1:0]   custom_hold;
    logic [TIME_W-1:0] custom_start;
    logic              fade_busy;
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now;
    logic [RGBW_W-1:0] rgbw;
    logic [MS_W-1:0]   duration;
    logic [MS_W-1:0]   transition;
    logic              done;
  } item_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [RGBW_W-1:0] rgbw;
    logic [MS_W-1:0]   fade;
    mode_t             mode;
  } result_t;

  function automatic logic [RGBW_W-1:0] pack_rgbw(
    input logic [COLOR_W-1:0] r,
    input logic [COLOR_W-1:0] g,
    input logic [COLOR_W-1:0] b,
    input logic [COLOR_W-1:0] w
  );
    return {w, b, g, r};
  endfunction

  // A negative wrapped difference never counts as elapsed.
  function automatic logic elapsed_over(
    input logic [TIME_W-1:0] a,
    input logic [TIME_W-1:0] b,
    input logic [MS_W-1:0]   limit
  );
    logic [TIME_W-1:0] d;
    d = a - b;
    return !d[TIME_W-1] && (d[MS_W-1:0] > limit);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lsms_step.sv]
// ----------------------------------------------------------------------------
// lsms_step
// Next-state and command logic for one event, applied to the held state.
// ----------------------------------------------------------------------------
`default_nettype none

module lsms_step (
  input  wire lsms_pkg::cfg_t    cfg,
  input  wire lsms_pkg::state_t  st,
  input  wire lsms_pkg::item_t   item,
  output lsms_pkg::state_t       st_nxt,
  output lsms_pkg::result_t      res
);

  logic                          ping_over;
  logic                          custom_over;
  logic                          active;
  logic [lsms_pkg::RGBW_W-1:0]   idle_rgbw;
  logic [lsms_pkg::RGBW_W-1:0]   active_rgbw;
  logic                          cmd_on;
  logic [lsms_pkg::RGBW_W-1:0]   cmd_rgbw;
  logic [lsms_pkg::MS_W-1:0]     cmd_fade;

  assign ping_over   = lsms_pkg::elapsed_over(item.now, st.ping_time, cfg.timeout);
  assign custom_over = lsms_pkg::elapsed_over(item.now, st.custom_start, st.custom_hold);
  assign active      = !cfg.dimming || (st.ping_valid && !ping_over);

  assign idle_rgbw = cfg.white ?
    lsms_pkg::pack_rgbw(lsms_pkg::LEVEL_ZERO, lsms_pkg::LEVEL_ZERO,
                        lsms_pkg::LEVEL_ZERO, lsms_pkg::LEVEL_DIM) :
    lsms_pkg::pack_rgbw(lsms_pkg::LEVEL_DIM, lsms_pkg::LEVEL_DIM,
                        lsms_pkg::LEVEL_DIM, lsms_pkg::LEVEL_DIM);
  assign active_rgbw = cfg.white ?
    lsms_pkg::pack_rgbw(lsms_pkg::LEVEL_ZERO, lsms_pkg::LEVEL_ZERO,
                        lsms_pkg::LEVEL_ZERO, lsms_pkg::LEVEL_FULL) :
    lsms_pkg::pack_rgbw(lsms_pkg::LEVEL_FULL, lsms_pkg::LEVEL_FULL,
                        lsms_pkg::LEVEL_FULL, lsms_pkg::LEVEL_FULL);

  always_comb begin
    st_nxt   = st;
    cmd_on   = 1'b0;
    cmd_rgbw = '0;
    cmd_fade = '0;
    case (lsms_pkg::func_t'(item.func))
      lsms_pkg::FUNC_TICK: begin
        if (cfg.dimming && st.ping_valid && ping_over) begin
          st_nxt.ping_valid = 1'b0;
        end
        case (st.mode)
          lsms_pkg::MODE_STARTUP: begin
            cmd_on      = 1'b1;
            cmd_rgbw    = idle_rgbw;
            cmd_fade    = lsms_pkg::IDLE_FADE_MS;
            st_nxt.mode = lsms_pkg::MODE_IDLE;
          end
          lsms_pkg::MODE_IDLE: begin
            if (st.custom_valid) begin
              cmd_on      = 1'b1;
              cmd_rgbw    = st.custom_rgbw;
              cmd_fade    = st.custom_fade;
              st_nxt.mode = lsms_pkg::MODE_CUSTOM;
            end else if (active) begin
              cmd_on      = 1'b1;
              cmd_rgbw    = active_rgbw;
              cmd_fade    = lsms_pkg::ACTIVE_FADE_MS;
              st_nxt.mode = lsms_pkg::MODE_ACTIVE;
            end
          end
          lsms_pkg::MODE_ACTIVE: begin
            if (st.custom_valid) begin
              cmd_on      = 1'b1;
              cmd_rgbw    = st.custom_rgbw;
              cmd_fade    = st.custom_fade;
              st_nxt.mode = lsms_pkg::MODE_CUSTOM;
            end else if (!active) begin
              cmd_on      = 1'b1;
              cmd_rgbw    = idle_rgbw;
              cmd_fade    = lsms_pkg::IDLE_FADE_MS;
              st_nxt.mode = lsms_pkg::MODE_IDLE;
            end
          end
          lsms_pkg::MODE_CUSTOM: begin
            // A zero hold in endless mode parks the color once the fade ends.
            if (!cfg.endless || (st.custom_hold != '0)) begin
              if (custom_over) begin
                st_nxt.custom_valid = 1'b0;
                cmd_on              = 1'b1;
                cmd_fade            = st.custom_fade;
                cmd_rgbw            = active ? active_rgbw : idle_rgbw;
                st_nxt.mode         = active ? lsms_pkg::MODE_ACTIVE
                                             : lsms_pkg::MODE_IDLE;
              end
            end else if (!st.fade_busy) begin
              st_nxt.custom_valid = 1'b0;
              st_nxt.mode         = lsms_pkg::MODE_ENDLESS;
            end
          end
          lsms_pkg::MODE_ENDLESS: begin
            if (cfg.endless && st.custom_valid) begin
              cmd_on      = 1'b1;
              cmd_rgbw    = st.custom_rgbw;
              cmd_fade    = st.custom_fade;
              st_nxt.mode = lsms_pkg::MODE_CUSTOM;
            end
          end
          lsms_pkg::MODE_SETOFF: begin
            cmd_on      = 1'b1;
            cmd_rgbw    = '0;
            cmd_fade    = lsms_pkg::OFF_FADE_MS;
            st_nxt.mode = lsms_pkg::MODE_OFF;
          end
          default: begin
          end
        endcase
        // A fade issued on this tick can already be reported finished.
        st_nxt.fade_busy = (st.fade_busy || cmd_on) && !item.done;
      end
      lsms_pkg::FUNC_PING: begin
        st_nxt.ping_valid = 1'b1;
        st_nxt.ping_time  = item.now;
      end
      lsms_pkg::FUNC_PRESENT: begin
        st_nxt.custom_valid = 1'b1;
        st_nxt.custom_rgbw  = item.rgbw;
        st_nxt.custom_hold  = item.duration;
        st_nxt.custom_fade  = item.transition;
        st_nxt.custom_start = item.now;
      end
      lsms_pkg::FUNC_ENABLE: begin
        st_nxt.mode = lsms_pkg::MODE_STARTUP;
      end
      lsms_pkg::FUNC_DISABLE: begin
        st_nxt.mode = lsms_pkg::MODE_SETOFF;
      end
      lsms_pkg::FUNC_PANIC_OFF: begin
        st_nxt.mode = lsms_pkg::MODE_OFF;
      end
      default: begin
      end
    endcase
  end

  assign res.cmd_valid = cmd_on;
  assign res.rgbw      = cmd_rgbw;
  assign res.fade      = cmd_fade;
  assign res.mode      = st_nxt.mode;

endmodule

`default_nettype wire

[hw/rtl/led_strip_mode_sequencer.sv]
// ----------------------------------------------------------------------------
// led_strip_mode_sequencer
// Event-driven mode sequencer for an LED strip that issues fade commands.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | func, now_ms, color_rgbw, duration, transition, done
//  out     | out_valid/out_stall| cmd_valid, target_rgbw, fade_ms, mode
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  An event is captured in an input register, evaluated against the mode
//  state and written to the output register: one event per cycle while the
//  output register is not stalled.
//  Reset puts the block in startup mode with all pending requests cleared.
//  A stalled output register holds the input register, which then stalls in.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_mode_sequencer (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [lsms_pkg::FUNC_W-1:0]        in_func,
  input  wire  [lsms_pkg::TIME_W-1:0]        in_now_ms,
  input  wire  [lsms_pkg::COLOR_W-1:0]       in_color_r,
  input  wire  [lsms_pkg::COLOR_W-1:0]       in_color_g,
  input  wire  [lsms_pkg::COLOR_W-1:0]       in_color_b,
  input  wire  [lsms_pkg::COLOR_W-1:0]       in_color_w,
  input  wire  [lsms_pkg::MS_W-1:0]          in_duration_ms,
  input  wire  [lsms_pkg::MS_W-1:0]          in_transition_ms,
  input  wire                                in_transition_done,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_cmd_valid,
  output logic [lsms_pkg::COLOR_W-1:0]       out_target_r,
  output logic [lsms_pkg::COLOR_W-1:0]       out_target_g,
  output logic [lsms_pkg::COLOR_W-1:0]       out_target_b,
  output logic [lsms_pkg::COLOR_W-1:0]       out_target_w,
  output logic [lsms_pkg::MS_W-1:0]          out_fade_ms,
  output logic [lsms_pkg::MODE_W-1:0]        out_mode,
  input  wire                                cfg_we,
  input  wire  [lsms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lsms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lsms_pkg::cfg_t    cfg_r;
  lsms_pkg::state_t  st_r;
  lsms_pkg::state_t  st_nxt;
  lsms_pkg::item_t   item_r;
  lsms_pkg::result_t res_nxt;
  lsms_pkg::result_t res_r;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              out_free;
  logic              fire;
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  lsms_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dimming <= 1'b1;
      cfg_r.white   <= 1'b0;
      cfg_r.endless <= 1'b0;
      cfg_r.timeout <= lsms_pkg::TIMEOUT_RST_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        lsms_pkg::CFG_DIMMING: cfg_r.dimming <= cfg_data[0];
        lsms_pkg::CFG_WHITE:   cfg_r.white   <= cfg_data[0];
        lsms_pkg::CFG_ENDLESS: cfg_r.endless <= cfg_data[0];
        lsms_pkg::CFG_TIMEOUT: cfg_r.timeout <= cfg_data[lsms_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= lsms_pkg::MODE_STARTUP;
      st_r.ping_valid   <= 1'b0;
      st_r.ping_time    <= '0;
      st_r.custom_valid <= 1'b0;
      st_r.custom_rgbw  <= '0;
      st_r.custom_fade  <= '0;
      st_r.custom_hold  <= '0;
      st_r.custom_start <= '0;
      st_r.fade_busy    <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func       <= in_func;
      item_r.now        <= in_now_ms;
      item_r.rgbw       <= lsms_pkg::pack_rgbw(in_color_r, in_color_g, in_color_b,
                                               in_color_w);
      item_r.duration   <= in_duration_ms;
      item_r.transition <= in_transition_ms;
      item_r.done       <= in_transition_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cmd_valid = res_r.cmd_valid;
  assign out_target_r  = res_r.rgbw[lsms_pkg::COLOR_W-1:0];
  assign out_target_g  = res_r.rgbw[2*lsms_pkg::COLOR_W-1:lsms_pkg::COLOR_W];
  assign out_target_b  = res_r.rgbw[3*lsms_pkg::COLOR_W-1:2*lsms_pkg::COLOR_W];
  assign out_target_w  = res_r.rgbw[4*lsms_pkg::COLOR_W-1:3*lsms_pkg::COLOR_W];
  assign out_fade_ms   = res_r.fade;
  assign out_mode      = res_r.mode;

endmodule

`default_nettype wire
